### sv/tt_pkg.sv
// Shared types and constants for the text tokenizer core.
// Holds the lexer mode and token kind codes, the token record and queue sizes.
// Depends on nothing; every other file refers to it by scoped names.
package tt_pkg;

    localparam int INT_W  = 32;
    localparam int LINE_W = 20;
    localparam int OFF_W  = 24;
    localparam int LEN_W  = 16;
    localparam int KIND_W = 3;

    localparam int LINE_BITS_DEF   = 20;
    localparam int OFFSET_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = RQ_PTR_W + 1;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_NAME  = 4'd1,
        M_STR   = 4'd2,
        M_DOT   = 4'd3,
        M_DEC   = 4'd4,
        M_HEX   = 4'd5,
        M_OCT   = 4'd6,
        M_BIN   = 4'd7,
        M_FRAC  = 4'd8,
        M_ESIGN = 4'd9,
        M_EDIG  = 4'd10
    } t_mode;

    typedef enum logic [KIND_W-1:0] {
        KIND_NAME    = 3'd0,
        KIND_STRING  = 3'd1,
        KIND_LITERAL = 3'd2,
        KIND_INT     = 3'd3,
        KIND_FLOAT   = 3'd4,
        KIND_PUNCT   = 3'd5
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [INT_W-1:0]   value;
        logic [LINE_W-1:0]  line;
        logic [OFF_W-1:0]   start;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_tok;

    typedef struct packed {
        logic [1:0] count;
        t_tok       r0;
        t_tok       r1;
    } t_lex_out;

endpackage

### sv/tt_lex.sv
// Lexer step of the text tokenizer: input register, lexer state and token records.
// Produces up to two token records per byte for the result queue.
// Depends on tt_pkg.
module tt_lex #(
    parameter int LINE_BITS   = tt_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = tt_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = tt_pkg::LENGTH_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_in_byte,
    input  logic             i_end_of_input,
    input  logic             i_space,
    output tt_pkg::t_lex_out o_lex
);

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_PL  = 8'h2B;
    localparam logic [7:0] CH_MI  = 8'h2D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_BSL = 8'h5C;
    localparam logic [7:0] CH_US  = 8'h5F;
    localparam logic [7:0] CH_E   = 8'h45;
    localparam logic [7:0] CH_LE  = 8'h65;
    localparam logic [7:0] CH_X   = 8'h78;
    localparam logic [7:0] CH_O   = 8'h6F;
    localparam logic [7:0] CH_B   = 8'h62;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SP) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    logic                   r_in_vld;
    logic [7:0]             r_byte;
    logic                   r_eoi;

    tt_pkg::t_mode          r_mode, n_mode;
    logic [31:0]            r_acc, n_acc;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [LINE_BITS-1:0]   r_tline, n_tline;
    logic [LENGTH_BITS-1:0] r_len, n_len;
    logic                   r_qd, n_qd;
    logic                   r_esc, n_esc;

    logic                   proc;
    logic                   e0, ep;
    tt_pkg::t_kind          k0;
    logic [LENGTH_BITS-1:0] len0;
    tt_pkg::t_tok           rec_first, rec_punct;

    assign proc       = r_in_vld && i_space;
    assign o_in_ready = !r_in_vld || i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready) begin
            r_byte <= i_in_byte;
            r_eoi  <= i_end_of_input;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tt_pkg::M_IDLE;
            r_acc    <= '0;
            r_line   <= '0;
            r_off    <= '0;
            r_tstart <= '0;
            r_tline  <= '0;
            r_len    <= '0;
            r_qd     <= 1'b0;
            r_esc    <= 1'b0;
        end else if (proc) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_line   <= n_line;
            r_off    <= n_off;
            r_tstart <= n_tstart;
            r_tline  <= n_tline;
            r_len    <= n_len;
            r_qd     <= n_qd;
            r_esc    <= n_esc;
        end
    end

    always_comb begin
        logic [7:0]             c;
        logic                   eoi;
        logic [3:0]             d;
        logic [3:0]             hv;
        logic                   hv_ok;
        logic                   ended;
        logic                   taken;
        logic                   start;
        logic [LENGTH_BITS-1:0] len_inc;
        logic [31:0]            w_line;
        logic [31:0]            w_len;
        logic [31:0]            w_pline;

        c       = r_byte;
        eoi     = r_eoi || (c == CH_NUL);
        d       = c[3:0];
        len_inc = (r_len == '1) ? r_len : r_len + 1'b1;
        hv_ok   = 1'b1;
        if (is_digit(c)) begin
            hv = c[3:0];
        end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
            hv = 4'(c[2:0] + 3'd1) + 4'd8;
        end else begin
            hv    = 4'd0;
            hv_ok = 1'b0;
        end

        n_mode   = r_mode;
        n_acc    = r_acc;
        n_line   = r_line;
        n_off    = r_off;
        n_tstart = r_tstart;
        n_tline  = r_tline;
        n_len    = r_len;
        n_qd     = r_qd;
        n_esc    = r_esc;
        e0       = 1'b0;
        ep       = 1'b0;
        len0     = r_len;
        ended    = 1'b0;
        taken    = 1'b0;
        start    = 1'b0;

        case (r_mode)
            tt_pkg::M_NAME: k0 = tt_pkg::KIND_NAME;
            tt_pkg::M_STR:  k0 = r_qd ? tt_pkg::KIND_STRING : tt_pkg::KIND_LITERAL;
            tt_pkg::M_DOT:  k0 = tt_pkg::KIND_PUNCT;
            tt_pkg::M_DEC, tt_pkg::M_HEX, tt_pkg::M_OCT, tt_pkg::M_BIN:
                            k0 = tt_pkg::KIND_INT;
            default:        k0 = tt_pkg::KIND_FLOAT;
        endcase

        if (eoi) begin
            e0     = (r_mode != tt_pkg::M_IDLE);
            n_mode = tt_pkg::M_IDLE;
            n_esc  = 1'b0;
        end else begin
            case (r_mode)
                tt_pkg::M_NAME: begin
                    if (is_alpha(c) || is_digit(c) || (c == CH_US)) taken = 1'b1;
                    else ended = 1'b1;
                end
                tt_pkg::M_STR: begin
                    n_len = len_inc;
                    if (r_esc) begin
                        n_esc = 1'b0;
                    end else if (c == CH_BSL) begin
                        n_esc = 1'b1;
                    end else if (c == (r_qd ? CH_DQ : CH_SQ)) begin
                        e0     = 1'b1;
                        len0   = len_inc;
                        n_mode = tt_pkg::M_IDLE;
                    end
                end
                tt_pkg::M_DOT: begin
                    if (is_digit(c)) begin
                        n_mode = tt_pkg::M_FRAC;
                        n_acc  = '0;
                        taken  = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_DEC: begin
                    if (is_digit(c)) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + 32'(d);
                        taken = 1'b1;
                    end else if ((r_acc == '0) && (c == CH_X)) begin
                        n_mode = tt_pkg::M_HEX;
                        taken  = 1'b1;
                    end else if ((r_acc == '0) && (c == CH_O)) begin
                        n_mode = tt_pkg::M_OCT;
                        taken  = 1'b1;
                    end else if ((r_acc == '0) && (c == CH_B)) begin
                        n_mode = tt_pkg::M_BIN;
                        taken  = 1'b1;
                    end else if (c == CH_DOT) begin
                        n_mode = tt_pkg::M_FRAC;
                        taken  = 1'b1;
                    end else if ((c == CH_LE) || (c == CH_E)) begin
                        n_mode = tt_pkg::M_ESIGN;
                        taken  = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_HEX: begin
                    if (hv_ok) begin
                        n_acc = (r_acc << 4) + 32'(hv);
                        taken = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_OCT: begin
                    if (is_digit(c)) begin
                        n_acc = (r_acc << 3) + 32'(d);
                        taken = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_BIN: begin
                    if (is_digit(c)) begin
                        n_acc = (r_acc << 1) + 32'(d);
                        taken = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_FRAC: begin
                    if (is_digit(c)) begin
                        taken = 1'b1;
                    end else if ((c == CH_LE) || (c == CH_E)) begin
                        n_mode = tt_pkg::M_ESIGN;
                        taken  = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_ESIGN: begin
                    if ((c == CH_PL) || (c == CH_MI) || is_digit(c)) begin
                        n_mode = tt_pkg::M_EDIG;
                        taken  = 1'b1;
                    end else begin
                        ended = 1'b1;
                    end
                end
                tt_pkg::M_EDIG: begin
                    if (is_digit(c)) taken = 1'b1;
                    else ended = 1'b1;
                end
                default: begin
                    n_mode = tt_pkg::M_IDLE;
                    start  = 1'b1;
                end
            endcase

            if (taken) n_len = len_inc;
            if (ended) begin
                e0     = 1'b1;
                n_mode = tt_pkg::M_IDLE;
                start  = 1'b1;
            end

            if (start && !is_space(c)) begin
                n_tstart = r_off;
                n_tline  = r_line;
                n_len    = LENGTH_BITS'(1);
                n_acc    = '0;
                if (is_alpha(c)) begin
                    n_mode = tt_pkg::M_NAME;
                end else if ((c == CH_DQ) || (c == CH_SQ)) begin
                    n_mode = tt_pkg::M_STR;
                    n_qd   = (c == CH_DQ);
                    n_esc  = 1'b0;
                end else if (is_digit(c)) begin
                    n_mode = tt_pkg::M_DEC;
                    n_acc  = 32'(d);
                end else if (c == CH_DOT) begin
                    n_mode = tt_pkg::M_DOT;
                end else begin
                    ep     = 1'b1;
                    n_mode = tt_pkg::M_IDLE;
                end
            end

            n_off = (r_off == '1) ? r_off : r_off + 1'b1;
            if (c == CH_LF) n_line = (r_line == '1) ? r_line : r_line + 1'b1;
        end

        w_line  = 32'(r_tline);
        w_len   = 32'(len0);
        w_pline = 32'(r_line);

        rec_first.kind   = k0;
        rec_first.value  = ((k0 == tt_pkg::KIND_INT) || (k0 == tt_pkg::KIND_FLOAT)) ? r_acc : '0;
        rec_first.line   = w_line[tt_pkg::LINE_W-1:0];
        rec_first.start  = tt_pkg::OFF_W'(r_tstart);
        rec_first.length = w_len[tt_pkg::LEN_W-1:0];
        rec_first.last   = !ep;

        rec_punct.kind   = tt_pkg::KIND_PUNCT;
        rec_punct.value  = '0;
        rec_punct.line   = w_pline[tt_pkg::LINE_W-1:0];
        rec_punct.start  = tt_pkg::OFF_W'(r_off);
        rec_punct.length = tt_pkg::LEN_W'(1);
        rec_punct.last   = 1'b1;

        o_lex.count = proc ? (2'(e0) + 2'(ep)) : 2'd0;
        o_lex.r0    = e0 ? rec_first : rec_punct;
        o_lex.r1    = rec_punct;
    end

endmodule

### sv/tt_resq.sv
// Result queue of the text tokenizer: four token records in registers.
// Takes up to two records a cycle from the lexer and hands out one a cycle while the consumer pops.
// Depends on tt_pkg.
module tt_resq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tt_pkg::t_lex_out i_lex,
    input  logic             i_pop,
    output tt_pkg::t_tok     o_head,
    output logic             o_valid,
    output logic             o_space
);

    tt_pkg::t_tok                r_mem [tt_pkg::RQ_DEPTH];
    logic [tt_pkg::RQ_PTR_W-1:0] r_wp, n_wp;
    logic [tt_pkg::RQ_PTR_W-1:0] r_rp, n_rp;
    logic [tt_pkg::RQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                        pop;

    assign o_valid = (r_cnt != '0);
    assign o_space = (r_cnt <= tt_pkg::RQ_CNT_W'(tt_pkg::RQ_DEPTH - 2));
    assign o_head  = r_mem[r_rp];
    assign pop     = o_valid && i_pop;

    always_comb begin
        n_wp  = r_wp + tt_pkg::RQ_PTR_W'(i_lex.count);
        n_rp  = r_rp + tt_pkg::RQ_PTR_W'(pop);
        n_cnt = r_cnt + tt_pkg::RQ_CNT_W'(i_lex.count) - tt_pkg::RQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_lex.count != 2'd0) r_mem[r_wp] <= i_lex.r0;
        if (i_lex.count == 2'd2) r_mem[r_wp + 1'b1] <= i_lex.r1;
    end

endmodule

### sv/text_tokenizer_core.sv
// Text tokenizer core: one source byte per request in, token records out.
// The byte that ends a token is held in the input register; its record is then written
// into the result queue and offered at its head when no earlier records wait there.
// Throughput: one byte per cycle while the queue has space; a punctuation byte ending a
// token gives two records, read singly via the one read port of the four-entry queue.
// Reset: synchronous, active low; clears lexer state, counters and the queue.
module text_tokenizer_core #(
    parameter int LINE_BITS   = tt_pkg::LINE_BITS_DEF,
    parameter int OFFSET_BITS = tt_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS = tt_pkg::LENGTH_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_in_byte,
    input  logic                            i_end_of_input,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tt_pkg::KIND_W-1:0]       o_token_kind,
    output logic signed [tt_pkg::INT_W-1:0] o_int_value,
    output logic [tt_pkg::LINE_W-1:0]       o_line_number,
    output logic [tt_pkg::OFF_W-1:0]        o_start_offset,
    output logic [tt_pkg::LEN_W-1:0]        o_token_length,
    output logic                            o_last_of_run
);

    tt_pkg::t_lex_out lex;
    tt_pkg::t_tok     head;
    logic             space;

    tt_lex #(
        .LINE_BITS   (LINE_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_lex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .i_space        (space),
        .o_lex          (lex)
    );

    tt_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lex   (lex),
        .i_pop   (i_out_ready),
        .o_head  (head),
        .o_valid (o_out_valid),
        .o_space (space)
    );

    assign o_token_kind   = head.kind;
    assign o_int_value    = head.value;
    assign o_line_number  = head.line;
    assign o_start_offset = head.start;
    assign o_token_length = head.length;
    assign o_last_of_run  = head.last;

    a_push_has_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lex.count != 2'd0) |-> space)
        else $error("token records pushed without queue space");

    a_second_is_punct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lex.count == 2'd2) |-> ((lex.r1.kind == tt_pkg::KIND_PUNCT) && !lex.r0.last
                                 && lex.r1.last))
        else $error("second record of a byte is not a closing punctuation record");

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lex.count == 2'd1) |-> lex.r0.last)
        else $error("single record of a byte is not marked last");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered right after reset");

endmodule
